@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the cache controller RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/lbc_pkg.sv @@
// Package for the LRU buffer cache controller.
// Holds operation and status codes, the sequencer states and default sizes; no dependencies.
`default_nettype none
package lbc_pkg;

	localparam int NBUF_DEF        = 16;
	localparam int BLOCK_BYTES_DEF = 512;
	localparam int ROOM_W          = 13;

	typedef enum logic [1:0] {
		FN_ACQ = 2'd0,
		FN_REL = 2'd1,
		FN_WR  = 2'd2,
		FN_NOP = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_BUSY = 3'd1,
		ST_FREE = 3'd2,
		ST_SAT  = 3'd3,
		ST_OFF  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACQ,
		S_DEC,
		S_RD,
		S_PROMO,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/lru_buffer_cache_controller_unit.sv @@
// Tag and replacement controller for a fully associative sector buffer cache.
// Depends on lbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The controller keeps one tag, valid bit, dirty bit, 8-bit reference count and
// LRU rank per entry in a synchronous entry memory with a single read port and
// serves one request at a time. An acquire scans every entry through the memory
// read port and then writes the chosen entry unless its count is saturated. A
// write and a release that leaves the count above zero read the indexed entry and
// write it back, and a request rejected on its index or offset goes to its result.
// A release that frees an entry rescans the memory to age the more recent entries.
// A stalled result side holds the sequencer in S_FIN for as long as the previous
// result still waits in the output register.
// A per-entry written flag, cleared by reset, makes untouched entries read as
// their reset value, so no clearing pass is needed after reset. A finished
// result waits in the output register while the next request is accepted.
module lru_buffer_cache_controller_unit #(
	parameter int NBUF        = lbc_pkg::NBUF_DEF,
	parameter int BLOCK_BYTES = lbc_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// device[7:0], sector[39:8], buffer_index[43:40], offset[55:44], length[67:56]
	input  wire logic [71:0] s_tdata,
	// func[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// entry[3:0], hit[4], need_fetch[5], need_writeback[6], wb_device[14:7],
	// wb_sector[46:15], write_len[56:47], status[59:57]
	output logic [63:0]      m_tdata
);
	import lbc_pkg::*;

	localparam int IW = (NBUF > 1) ? $clog2(NBUF) : 1;
	localparam int CW = IW + 1;

	typedef struct packed {
		logic [7:0]    dev;
		logic [31:0]   sec;
		logic          vld;
		logic          dirty;
		logic [7:0]    cnt;
		logic [IW-1:0] rank;
	} entry_t;

	// Request fields split out of the stream.
	logic [7:0]  device;
	logic [31:0] sector;
	logic [3:0]  buffer_index;
	logic [11:0] offset;
	logic [11:0] length;
	assign device       = s_tdata[7:0];
	assign sector       = s_tdata[39:8];
	assign buffer_index = s_tdata[43:40];
	assign offset       = s_tdata[55:44];
	assign length       = s_tdata[67:56];

	// Value an entry holds before it is first written.
	function automatic entry_t rst_entry(input logic [IW-1:0] i);
		entry_t e;
		e      = '0;
		e.rank = IW'(NBUF - 1) - i;
		return e;
	endfunction

	state_t        state_q, state_d;
	func_t         op_q;
	logic [7:0]    dev_q;
	logic [31:0]   sec_q;
	logic [IW-1:0] idx_q;
	logic [11:0]   off_q;
	logic [11:0]   len_q;
	logic [CW-1:0] cnt_q;

	// Scan bookkeeping for acquire.
	logic          found_q;
	logic [IW-1:0] found_idx_q;
	entry_t        found_ent_q;
	logic          vic_q;
	logic [IW-1:0] vic_idx_q;
	logic [IW-1:0] vic_rank_q;

	// Release that frees an entry: the new word and the rank it leaves.
	entry_t        upd_q;
	logic [IW-1:0] old_rank_q;

	// Result being built.
	logic [3:0]  res_entry_q;
	logic        res_hit_q;
	logic        res_fetch_q;
	logic        res_wb_q;
	logic [7:0]  res_dev_q;
	logic [31:0] res_sec_q;
	logic [9:0]  res_len_q;
	status_t     res_status_q;

	// Entry memory and its read pipeline.
	entry_t        mem [NBUF];
	entry_t        mem_q;
	logic [NBUF-1:0] init_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          we;
	logic [IW-1:0] wa;
	entry_t        wd;
	entry_t        ent;
	logic          last;
	logic          scan_more;
	logic          idx_ok;
	logic          off_ok;
	logic          match;
	logic [ROOM_W-1:0] room;
	logic [ROOM_W-1:0] clip;

	assign ent       = init_q[rd_idx_s1] ? mem_q : rst_entry(rd_idx_s1);
	assign last      = rd_vld_s1 && (rd_idx_s1 == IW'(NBUF - 1));
	assign scan_more = (cnt_q < CW'(NBUF));
	assign idx_ok    = (32'(buffer_index) < NBUF);
	assign off_ok    = (32'(offset) < BLOCK_BYTES);
	assign match     = ent.vld && (ent.dev == dev_q) && (ent.sec == sec_q);
	assign room      = ROOM_W'(BLOCK_BYTES) - ROOM_W'(off_q);
	assign clip      = (ROOM_W'(len_q) > room) ? room : ROOM_W'(len_q);

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (rd_en)
			mem_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
			init_q    <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (we)
				init_q[wa] <= 1'b1;
			if (state_q == S_FIN && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	// Next state, memory port control and request handshake.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cnt_q[IW-1:0];
		we       = 1'b0;
		wa       = rd_idx_s1;
		wd       = ent;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (func_t'(s_tuser))
						FN_ACQ: state_d = S_ACQ;
						FN_REL: begin
							if (idx_ok) begin
								rd_en   = 1'b1;
								rd_addr = IW'(buffer_index);
								state_d = S_RD;
							end else begin
								state_d = S_FIN;
							end
						end
						FN_WR: begin
							if (idx_ok && off_ok) begin
								rd_en   = 1'b1;
								rd_addr = IW'(buffer_index);
								state_d = S_RD;
							end else begin
								state_d = S_FIN;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_ACQ: begin
				rd_en = scan_more;
				if (last)
					state_d = S_DEC;
			end
			S_DEC: begin
				if (found_q) begin
					we      = (found_ent_q.cnt != 8'hFF);
					wa      = found_idx_q;
					wd      = found_ent_q;
					wd.cnt  = found_ent_q.cnt + 8'd1;
				end else if (vic_q) begin
					we       = 1'b1;
					wa       = vic_idx_q;
					wd.dev   = dev_q;
					wd.sec   = sec_q;
					wd.vld   = 1'b1;
					wd.dirty = 1'b0;
					wd.cnt   = 8'd1;
					wd.rank  = vic_rank_q;
				end
				state_d = S_FIN;
			end
			S_RD: begin
				state_d = S_FIN;
				wa      = idx_q;
				if (op_q == FN_REL) begin
					if (ent.cnt == 8'd1) begin
						state_d = S_PROMO;
					end else if (ent.cnt != 8'd0) begin
						we     = 1'b1;
						wd.cnt = ent.cnt - 8'd1;
					end
				end else begin
					we       = 1'b1;
					wd.dirty = 1'b1;
				end
			end
			S_PROMO: begin
				rd_en = scan_more;
				if (rd_vld_s1) begin
					if (rd_idx_s1 == idx_q) begin
						we = 1'b1;
						wd = upd_q;
					end else if (ent.rank < old_rank_q) begin
						we      = 1'b1;
						wd.rank = ent.rank + IW'(1);
					end
				end
				if (last)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (!m_tvalid || m_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Request capture, scan bookkeeping and result fields.
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_idx_s1 <= rd_addr;
		if (rd_en && state_q != S_IDLE)
			cnt_q <= cnt_q + CW'(1);
		case (state_q)
			S_IDLE: begin
				op_q        <= func_t'(s_tuser);
				dev_q       <= device;
				sec_q       <= sector;
				idx_q       <= IW'(buffer_index);
				off_q       <= offset;
				len_q       <= length;
				cnt_q       <= '0;
				found_q     <= 1'b0;
				vic_q       <= 1'b0;
				res_hit_q   <= 1'b0;
				res_fetch_q <= 1'b0;
				res_wb_q    <= 1'b0;
				res_dev_q   <= '0;
				res_sec_q   <= '0;
				res_len_q   <= '0;
				// Release and write report the index they were given.
				res_entry_q <= (func_t'(s_tuser) == FN_REL || func_t'(s_tuser) == FN_WR) ?
					buffer_index : 4'd0;
				res_status_q <= (func_t'(s_tuser) == FN_REL && !idx_ok) ? ST_FREE :
					(func_t'(s_tuser) == FN_WR && !(idx_ok && off_ok)) ? ST_OFF : ST_OK;
			end
			S_ACQ: begin
				if (rd_vld_s1) begin
					if (match && (!found_q || ent.rank < found_ent_q.rank)) begin
						found_q     <= 1'b1;
						found_idx_q <= rd_idx_s1;
						found_ent_q <= ent;
					end
					if (ent.cnt == 8'd0 && (!vic_q || ent.rank > vic_rank_q)) begin
						vic_q      <= 1'b1;
						vic_idx_q  <= rd_idx_s1;
						vic_rank_q <= ent.rank;
					end
				end
			end
			S_DEC: begin
				if (found_q) begin
					res_entry_q <= 4'(found_idx_q);
					res_hit_q   <= 1'b1;
					if (found_ent_q.cnt == 8'hFF)
						res_status_q <= ST_SAT;
				end else if (vic_q) begin
					res_entry_q <= 4'(vic_idx_q);
					res_fetch_q <= 1'b1;
					res_dev_q   <= dev_q;
					res_sec_q   <= sec_q;
				end else begin
					res_status_q <= ST_BUSY;
				end
			end
			S_RD: begin
				if (op_q == FN_REL) begin
					if (ent.cnt == 8'd0) begin
						res_status_q <= ST_FREE;
					end else if (ent.cnt == 8'd1) begin
						// Freed: a dirty entry goes out for writeback and is cleaned.
						res_wb_q   <= ent.dirty;
						res_dev_q  <= ent.dirty ? ent.dev : 8'd0;
						res_sec_q  <= ent.dirty ? ent.sec : 32'd0;
						upd_q      <= {ent.dev, ent.sec, ent.vld, 1'b0, 8'd0, IW'(0)};
						old_rank_q <= ent.rank;
						cnt_q      <= '0;
					end
				end else begin
					res_len_q <= 10'(clip);
				end
			end
			S_FIN: begin
				if (!m_tvalid || m_tready)
					m_tdata <= {4'd0, 3'(res_status_q), res_len_q, res_sec_q, res_dev_q,
						res_wb_q, res_fetch_q, res_hit_q, res_entry_q};
			end
			default: begin
			end
		endcase
	end

	`ASSERT_NEVER(a_write_when_idle, we && (state_q == S_IDLE || state_q == S_FIN),
		"entry memory written outside a working state")
	`ASSERT_HOLDS(a_read_data_used, rd_vld_s1 |-> (state_q == S_ACQ || state_q == S_RD ||
		state_q == S_PROMO), "read data returned with no scan or lookup in progress")
	`ASSERT_HOLDS(a_fin_holds, (state_q == S_FIN && m_tvalid && !m_tready) |=>
		(state_q == S_FIN), "finished result dropped while output register was full")

endmodule
`default_nettype wire
